// ----- rtl/llpo_pkg.sv -----
// Shared types and constants for the least-loaded peer offload unit.
package llpo_pkg;

  localparam int NUM_PEERS  = 16;
  localparam int LOAD_WIDTH = 10;
  localparam int PEER_W     = 4;
  localparam int THR_W      = 10;
  localparam int PIDX_W     = $clog2(NUM_PEERS);
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SEND    = 2'd1,
    ACT_REQUEUE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } scan_state_t;

  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic                  vld;
    logic [LOAD_WIDTH-1:0] load;
  } rd_rsp_t;

  typedef struct packed {
    logic [LOAD_WIDTH-1:0] load;
    action_t               action;
    logic [PEER_W-1:0]     target;
  } result_t;

endpackage

// ----- rtl/llpo_table.sv -----
// Peer load memory with per-entry valid bits and a registered read port.
module llpo_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [llpo_pkg::PIDX_W-1:0]    wr_addr,
  input  logic [llpo_pkg::LOAD_WIDTH-1:0] wr_load,
  input  llpo_pkg::rd_req_t              rd_req,
  output llpo_pkg::rd_rsp_t              rd_rsp
);
  import llpo_pkg::*;

  logic [LOAD_WIDTH-1:0] mem [NUM_PEERS];
  logic [NUM_PEERS-1:0]  vld_r;
  logic [LOAD_WIDTH-1:0] rd_load_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_load;
    end
    if (rd_req.en) begin
      rd_load_r <= mem[rd_req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_vld_r <= vld_r[rd_req.addr];
      end
    end
  end

  assign rd_rsp.vld  = rd_vld_r;
  assign rd_rsp.load = rd_load_r;

endmodule

// ----- rtl/llpo_scan.sv -----
// Tick sequencer: walks the peer table one entry per cycle for the least load.
module llpo_scan (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [llpo_pkg::LOAD_WIDTH-1:0] start_load,
  input  logic [llpo_pkg::THR_W-1:0]      thr,
  output llpo_pkg::rd_req_t               rd_req,
  input  llpo_pkg::rd_rsp_t               rd_rsp,
  output logic                            idle,
  output logic                            res_valid,
  output llpo_pkg::result_t               res,
  input  logic                            res_take
);
  import llpo_pkg::*;

  scan_state_t           st_r, st_nxt;
  logic [PIDX_W-1:0]     idx_r;
  logic [PIDX_W-1:0]     pend_idx_r;
  logic                  pend_r;
  logic [LOAD_WIDTH-1:0] len_r;
  logic [LOAD_WIDTH-1:0] best_r;
  logic [PIDX_W-1:0]     tgt_r;
  logic                  found_r;
  logic                  above_r;
  logic                  last_idx;

  assign last_idx = (idx_r == PIDX_W'(NUM_PEERS - 1));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = (start_load > thr) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: st_nxt = S_DONE;
      S_DONE: begin
        if (res_take) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_req.en   = 1'b0;
    rd_req.addr = idx_r;
    idle        = 1'b0;
    res_valid   = 1'b0;
    case (st_r)
      S_IDLE:  idle      = 1'b1;
      S_SCAN:  rd_req.en = 1'b1;
      S_DRAIN: ;
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= rd_req.en;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= idx_r;
    if (st_r == S_IDLE && start) begin
      len_r   <= start_load;
      above_r <= start_load > thr;
      best_r  <= start_load - 1'b1;
      tgt_r   <= '0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (st_r == S_SCAN) begin
        idx_r <= idx_r + 1'b1;
      end
      if (pend_r && rd_rsp.vld && rd_rsp.load < best_r) begin
        best_r  <= rd_rsp.load;
        tgt_r   <= pend_idx_r;
        found_r <= 1'b1;
      end
    end
  end

  always_comb begin
    res.load   = len_r;
    res.target = PEER_W'(tgt_r);
    if (!above_r) begin
      res.action = ACT_NONE;
    end else if (found_r) begin
      res.action = ACT_SEND;
    end else begin
      res.action = ACT_REQUEUE;
    end
  end

endmodule

// ----- rtl/least_loaded_peer_offload_unit.sv -----
// Top level: least-loaded peer offload unit with stream ports and output register.
// Load update: accepted, written to the table, no result.
// Tick above threshold: reads every table entry in turn (one entry per cycle, one RAM
// read port), then a drain state; the result goes through the output register to out_tvalid.
// Tick at or below threshold: no table reads; the result goes to the output register.
// Synchronous active-low reset clears all valid bits and sets the threshold to 4.
module least_loaded_peer_offload_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [llpo_pkg::THR_W-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // peer_id [3:0], load_value [13:4], zero [15:14]
  input  logic [llpo_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd [0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // broadcast_load [9:0], offload_action [11:10], target_peer [15:12]
  output logic [llpo_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import llpo_pkg::*;

  logic [THR_W-1:0]      thr_r;
  logic                  in_acc;
  logic [PEER_W-1:0]     in_pid;
  logic [LOAD_WIDTH-1:0] in_load;
  logic                  tbl_wr_en;
  rd_req_t               rd_req;
  rd_rsp_t               rd_rsp;
  logic                  scan_idle;
  logic                  res_valid;
  result_t               res;
  logic                  res_take;
  logic                  out_valid_r;
  result_t               out_res_r;

  assign in_pid  = in_tdata[PEER_W-1:0];
  assign in_load = in_tdata[PEER_W +: LOAD_WIDTH];

  assign in_tready = scan_idle;
  assign in_acc    = in_tvalid && in_tready;
  assign tbl_wr_en = in_acc && (in_tuser == CMD_UPDATE) && (32'(in_pid) < NUM_PEERS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(4);
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  llpo_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (PIDX_W'(in_pid)),
    .wr_load (in_load),
    .rd_req  (rd_req),
    .rd_rsp  (rd_rsp)
  );

  llpo_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc && (in_tuser == CMD_TICK)),
    .start_load (in_load),
    .thr        (thr_r),
    .rd_req     (rd_req),
    .rd_rsp     (rd_rsp),
    .idle       (scan_idle),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.target, out_res_r.action, out_res_r.load};

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !scan_idle |-> !tbl_wr_en)
    else $error("table written during a scan");

  a_target_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.action != ACT_SEND |-> out_res_r.target == '0)
    else $error("target set without send action");

  a_offload_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.action != ACT_NONE |-> out_res_r.load != '0)
    else $error("offload with empty queue");

endmodule
